@@ design/prt_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// prt_pkg
// shared types and constants for the pending reply table
// ----------------------------------------------------------------------------
package prt_pkg;

    localparam int unsigned ENTRIES_DEFAULT = 2;
    localparam logic [31:0] DEFAULT_TIMEOUT_RESET = 32'd20000;

    typedef logic [2:0] opcode_t;

    localparam opcode_t OP_ALLOC   = 3'd0;
    localparam opcode_t OP_RELEASE = 3'd1;
    localparam opcode_t OP_MATCH   = 3'd2;
    localparam opcode_t OP_TICK    = 3'd3;
    localparam opcode_t OP_POLL    = 3'd4;
    localparam opcode_t OP_CLEAR   = 3'd5;

    typedef logic [1:0] status_t;

    localparam status_t STATUS_OK   = 2'd0;
    localparam status_t STATUS_FULL = 2'd1;
    localparam status_t STATUS_NONE = 2'd2;

    typedef enum logic [0:0] {
        S_IDLE,
        S_RESP
    } state_t;

    typedef struct packed {
        logic execute;
    } prt_cmd_t;

endpackage
`default_nettype wire

@@ design/pending_reply_table.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pending_reply_table
// table of outstanding calls awaiting replies, with per-entry timeouts
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one operation word: opcode in tuser, serial, message id,
//   timeout and the two flags in tdata. m_axis returns one result word per
//   operation: status in tuser, found serial and message id in tdata.
//   cfg_valid/cfg_data write the default timeout; write it only while idle.
//   the result word is valid in the cycle after the operation word is
//   taken. the controller takes a new word only after the previous result
//   word has been taken. all entries are compared in parallel, so the
//   execute step does not depend on ENTRIES.
//   reset: all entries free, default timeout 20000 ticks.
//   a stalled receiver holds the result word and keeps s_axis_tready low.
// ----------------------------------------------------------------------------
module pending_reply_table #(
    parameter int unsigned ENTRIES = prt_pkg::ENTRIES_DEFAULT
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // serial[31:0], message_id[63:32], timeout_ticks[95:64],
    // no_reply_expected[96], is_method_call[97], zero pad
    input  wire logic [103:0] s_axis_tdata,
    // opcode[2:0]
    input  wire logic [2:0]   s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // found_serial[31:0], found_message_id[63:32]
    output logic [63:0]       m_axis_tdata,
    // status[1:0]
    output logic [1:0]        m_axis_tuser,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [31:0]  cfg_data
);
    import prt_pkg::*;

    prt_cmd_t    cmd;
    status_t     status;
    logic [31:0] found_serial;
    logic [31:0] found_message_id;

    assign cfg_ready = 1'b1;

    prt_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cmd           (cmd)
    );

    prt_datapath #(
        .ENTRIES (ENTRIES)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .opcode            (s_axis_tuser),
        .serial            (s_axis_tdata[31:0]),
        .message_id        (s_axis_tdata[63:32]),
        .timeout_ticks     (s_axis_tdata[95:64]),
        .no_reply_expected (s_axis_tdata[96]),
        .is_method_call    (s_axis_tdata[97]),
        .cfg_write         (cfg_valid & cfg_ready),
        .cfg_data          (cfg_data),
        .status            (status),
        .found_serial      (found_serial),
        .found_message_id  (found_message_id)
    );

    assign m_axis_tuser = status;
    assign m_axis_tdata = {found_message_id, found_serial};

endmodule
`default_nettype wire

@@ design/prt_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// prt_ctrl
// handshake controller: takes one word, then holds the result until taken
// ----------------------------------------------------------------------------
module prt_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            s_axis_tvalid,
    output logic                 s_axis_tready,
    output logic                 m_axis_tvalid,
    input  wire logic            m_axis_tready,
    output prt_pkg::prt_cmd_t    cmd
);
    import prt_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                if (m_axis_tready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        cmd.execute   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_axis_tready = 1'b1;
                cmd.execute   = s_axis_tvalid;
            end
            S_RESP:
            begin
                m_axis_tvalid = 1'b1;
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

endmodule
`default_nettype wire

@@ design/prt_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// prt_datapath
// entry storage, parallel serial and timeout compares, result register
// ----------------------------------------------------------------------------
module prt_datapath #(
    parameter int unsigned ENTRIES = prt_pkg::ENTRIES_DEFAULT
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire prt_pkg::prt_cmd_t cmd,
    input  wire prt_pkg::opcode_t  opcode,
    input  wire logic [31:0]       serial,
    input  wire logic [31:0]       message_id,
    input  wire logic [31:0]       timeout_ticks,
    input  wire logic              no_reply_expected,
    input  wire logic              is_method_call,
    input  wire logic              cfg_write,
    input  wire logic [31:0]       cfg_data,
    output prt_pkg::status_t       status,
    output logic [31:0]            found_serial,
    output logic [31:0]            found_message_id
);
    import prt_pkg::*;

    logic [31:0] serial_reg     [ENTRIES];
    logic [31:0] serial_next    [ENTRIES];
    logic [31:0] mid_reg        [ENTRIES];
    logic [31:0] mid_next       [ENTRIES];
    logic [31:0] timeout_reg    [ENTRIES];
    logic [31:0] timeout_next   [ENTRIES];
    logic [31:0] elapsed_reg    [ENTRIES];
    logic [31:0] elapsed_next   [ENTRIES];
    logic [31:0] dflt_tmo_reg;

    status_t     status_reg;
    status_t     status_next;
    logic [31:0] fser_reg;
    logic [31:0] fser_next;
    logic [31:0] fmid_reg;
    logic [31:0] fmid_next;

    logic [ENTRIES-1:0] free_vec;
    logic [ENTRIES-1:0] hit_vec;
    logic [ENTRIES-1:0] exp_vec;
    logic [ENTRIES-1:0] free_sel;
    logic [ENTRIES-1:0] hit_sel;
    logic [ENTRIES-1:0] exp_sel;
    logic [31:0]        hit_mid;
    logic [31:0]        exp_mid;
    logic [31:0]        exp_ser;
    logic [31:0]        new_tmo;

    function automatic logic [ENTRIES-1:0] lowest_one(input logic [ENTRIES-1:0] vec);
        logic [ENTRIES-1:0] res;
        logic               seen;
        res  = '0;
        seen = 1'b0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (vec[i] && !seen)
            begin
                res[i] = 1'b1;
                seen   = 1'b1;
            end
        end
        return res;
    endfunction

    // parallel compares over all entries
    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            free_vec[i] = (serial_reg[i] == 32'd0);
            hit_vec[i]  = (serial != 32'd0) && (serial_reg[i] == serial);
            exp_vec[i]  = (serial_reg[i] != 32'd0) && (elapsed_reg[i] > timeout_reg[i]);
        end
    end

    assign free_sel = lowest_one(free_vec);
    assign hit_sel  = lowest_one(hit_vec);
    assign exp_sel  = lowest_one(exp_vec);
    assign new_tmo  = (timeout_ticks != 32'd0) ? timeout_ticks : dflt_tmo_reg;

    always_comb
    begin
        hit_mid = '0;
        exp_mid = '0;
        exp_ser = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (hit_sel[i])
            begin
                hit_mid = hit_mid | mid_reg[i];
            end
            if (exp_sel[i])
            begin
                exp_mid = exp_mid | mid_reg[i];
                exp_ser = exp_ser | serial_reg[i];
            end
        end
    end

    always_comb
    begin
        serial_next  = serial_reg;
        mid_next     = mid_reg;
        timeout_next = timeout_reg;
        elapsed_next = elapsed_reg;
        status_next  = status_reg;
        fser_next    = fser_reg;
        fmid_next    = fmid_reg;
        if (cmd.execute)
        begin
            status_next = STATUS_OK;
            fser_next   = '0;
            fmid_next   = '0;
            case (opcode)
                OP_ALLOC:
                begin
                    if (!no_reply_expected)
                    begin
                        if (free_vec == '0)
                        begin
                            status_next = STATUS_FULL;
                        end
                        else
                        begin
                            for (int i = 0; i < ENTRIES; i++)
                            begin
                                if (free_sel[i])
                                begin
                                    serial_next[i]  = serial;
                                    mid_next[i]     = message_id;
                                    timeout_next[i] = new_tmo;
                                    elapsed_next[i] = '0;
                                end
                            end
                        end
                    end
                end
                OP_RELEASE:
                begin
                    if (is_method_call && (hit_vec != '0))
                    begin
                        for (int i = 0; i < ENTRIES; i++)
                        begin
                            if (hit_sel[i])
                            begin
                                serial_next[i] = '0;
                            end
                        end
                    end
                    else
                    begin
                        status_next = STATUS_NONE;
                    end
                end
                OP_MATCH:
                begin
                    if (hit_vec != '0)
                    begin
                        fmid_next = hit_mid;
                        for (int i = 0; i < ENTRIES; i++)
                        begin
                            if (hit_sel[i])
                            begin
                                serial_next[i] = '0;
                            end
                        end
                    end
                    else
                    begin
                        status_next = STATUS_NONE;
                    end
                end
                OP_TICK:
                begin
                    // saturating, free entries count too
                    for (int i = 0; i < ENTRIES; i++)
                    begin
                        if (elapsed_reg[i] != '1)
                        begin
                            elapsed_next[i] = elapsed_reg[i] + 32'd1;
                        end
                    end
                end
                OP_POLL:
                begin
                    if (exp_vec != '0)
                    begin
                        fser_next = exp_ser;
                        fmid_next = exp_mid;
                        for (int i = 0; i < ENTRIES; i++)
                        begin
                            if (exp_sel[i])
                            begin
                                serial_next[i] = '0;
                            end
                        end
                    end
                    else
                    begin
                        status_next = STATUS_NONE;
                    end
                end
                OP_CLEAR:
                begin
                    for (int i = 0; i < ENTRIES; i++)
                    begin
                        serial_next[i]  = '0;
                        mid_next[i]     = '0;
                        timeout_next[i] = '0;
                        elapsed_next[i] = '0;
                    end
                end
                default:
                begin
                    status_next = STATUS_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                serial_reg[i]  <= '0;
                mid_reg[i]     <= '0;
                timeout_reg[i] <= '0;
                elapsed_reg[i] <= '0;
            end
            dflt_tmo_reg <= DEFAULT_TIMEOUT_RESET;
        end
        else
        begin
            serial_reg  <= serial_next;
            mid_reg     <= mid_next;
            timeout_reg <= timeout_next;
            elapsed_reg <= elapsed_next;
            if (cfg_write)
            begin
                dflt_tmo_reg <= cfg_data;
            end
        end
    end

    // result word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg <= STATUS_OK;
            fser_reg   <= '0;
            fmid_reg   <= '0;
        end
        else
        begin
            status_reg <= status_next;
            fser_reg   <= fser_next;
            fmid_reg   <= fmid_next;
        end
    end

    assign status           = status_reg;
    assign found_serial     = fser_reg;
    assign found_message_id = fmid_reg;

endmodule
`default_nettype wire

@@ tb/tb_pending_reply_table.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pending_reply_table
// self-checking bench for the pending reply table: operation words go in on
// s_axis with random gaps, result words come back on m_axis under random
// and long stalls, and a shadow copy of the table predicts every result word.
// the default timeout is rewritten between traffic phases while idle.
// ----------------------------------------------------------------------------
module tb_pending_reply_table;

    import prt_pkg::*;

    localparam int unsigned SLOTS       = prt_pkg::ENTRIES_DEFAULT;
    localparam int          CYCLE_LIMIT = 300000;
    localparam opcode_t     OP_UNUSED_6 = 3'd6;
    localparam opcode_t     OP_UNUSED_7 = 3'd7;

    typedef struct {
        opcode_t     op;
        logic [31:0] serial;
        logic [31:0] message_id;
        logic [31:0] timeout_ticks;
        logic        no_reply_expected;
        logic        is_method_call;
    } table_op_t;

    typedef struct {
        status_t     status;
        logic [31:0] found_serial;
        logic [31:0] found_message_id;
    } table_result_t;

    class reply_table_shadow;
        logic [31:0]   slot_serial[SLOTS];
        logic [31:0]   slot_message_id[SLOTS];
        logic [31:0]   slot_timeout[SLOTS];
        logic [31:0]   slot_elapsed[SLOTS];
        logic [31:0]   default_timeout;
        table_result_t owed_results[$];
        int            err_count;

        function new();
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_serial[i]     = '0;
                slot_message_id[i] = '0;
                slot_timeout[i]    = '0;
                slot_elapsed[i]    = '0;
            end
            default_timeout = DEFAULT_TIMEOUT_RESET;
            err_count       = 0;
        endfunction

        function void set_default_timeout(logic [31:0] value);
            default_timeout = value;
        endfunction

        function int owed_count();
            return owed_results.size();
        endfunction

        // serial zero never matches
        function int slot_of(logic [31:0] serial);
            if (serial == 32'd0)
                return -1;
            for (int i = 0; i < SLOTS; i++)
                if (slot_serial[i] == serial)
                    return i;
            return -1;
        endfunction

        function void apply_op(table_op_t t);
            table_result_t r;
            int            hit;
            r.status           = STATUS_OK;
            r.found_serial     = '0;
            r.found_message_id = '0;
            hit                = -1;
            case (t.op)
                OP_ALLOC:
                begin
                    if (!t.no_reply_expected)
                    begin
                        for (int i = 0; i < SLOTS; i++)
                            if (hit < 0 && slot_serial[i] == 32'd0)
                                hit = i;
                        if (hit < 0)
                            r.status = STATUS_FULL;
                        else
                        begin
                            slot_serial[hit]     = t.serial;
                            slot_message_id[hit] = t.message_id;
                            slot_timeout[hit]    = (t.timeout_ticks != 32'd0) ?
                                                   t.timeout_ticks : default_timeout;
                            slot_elapsed[hit]    = '0;
                        end
                    end
                end
                OP_RELEASE:
                begin
                    if (t.is_method_call)
                        hit = slot_of(t.serial);
                    if (hit < 0)
                        r.status = STATUS_NONE;
                    else
                        slot_serial[hit] = '0;
                end
                OP_MATCH:
                begin
                    hit = slot_of(t.serial);
                    if (hit < 0)
                        r.status = STATUS_NONE;
                    else
                    begin
                        r.found_message_id = slot_message_id[hit];
                        slot_serial[hit]   = '0;
                    end
                end
                OP_TICK:
                begin
                    for (int i = 0; i < SLOTS; i++)
                        if (slot_elapsed[i] != 32'hFFFF_FFFF)
                            slot_elapsed[i] = slot_elapsed[i] + 32'd1;
                end
                OP_POLL:
                begin
                    r.status = STATUS_NONE;
                    for (int i = 0; i < SLOTS; i++)
                        if (hit < 0 && slot_serial[i] != 32'd0 &&
                            slot_elapsed[i] > slot_timeout[i])
                            hit = i;
                    if (hit >= 0)
                    begin
                        r.status           = STATUS_OK;
                        r.found_serial     = slot_serial[hit];
                        r.found_message_id = slot_message_id[hit];
                        slot_serial[hit]   = '0;
                    end
                end
                OP_CLEAR:
                begin
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        slot_serial[i]     = '0;
                        slot_message_id[i] = '0;
                        slot_timeout[i]    = '0;
                        slot_elapsed[i]    = '0;
                    end
                end
                default:
                begin
                end
            endcase
            owed_results.push_back(r);
        endfunction

        function void compare_result(status_t status, logic [31:0] fser, logic [31:0] fmid);
            table_result_t want;
            if (owed_results.size() == 0)
            begin
                $error("result word with nothing outstanding: status %0d", status);
                err_count++;
                return;
            end
            want = owed_results.pop_front();
            if (status !== want.status)
            begin
                $error("status: expected %0d, actual %0d", want.status, status);
                err_count++;
            end
            if (fser !== want.found_serial)
            begin
                $error("found_serial: expected %h, actual %h", want.found_serial, fser);
                err_count++;
            end
            if (fmid !== want.found_message_id)
            begin
                $error("found_message_id: expected %h, actual %h",
                       want.found_message_id, fmid);
                err_count++;
            end
        endfunction
    endclass

    logic          clk            = 1'b0;
    logic          rst_n          = 1'b0;
    logic          s_axis_tvalid  = 1'b0;
    logic          s_axis_tready;
    logic [103:0]  s_axis_tdata   = '0;
    logic [2:0]    s_axis_tuser   = '0;
    logic          m_axis_tvalid;
    logic          m_axis_tready  = 1'b0;
    logic [63:0]   m_axis_tdata;
    logic [1:0]    m_axis_tuser;
    logic          cfg_valid      = 1'b0;
    logic          cfg_ready;
    logic [31:0]   cfg_data       = '0;

    int send_idle_pct    = 0;
    int recv_stall_pct   = 0;
    int hold_off_request = 0;
    int hold_left        = 0;
    int cycles           = 0;

    reply_table_shadow shadow = new();

    pending_reply_table dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // result side: check taken words, then choose next ready
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            shadow.compare_result(m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[63:32]);
        if (hold_off_request > 0)
        begin
            hold_left        = hold_off_request;
            hold_off_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left     = hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    initial
    begin : watchdog
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic send_word(table_op_t t);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= t.op;
        s_axis_tdata  <= {6'b0, t.is_method_call, t.no_reply_expected,
                          t.timeout_ticks, t.message_id, t.serial};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        shadow.apply_op(t);
    endtask

    task automatic drive_op(opcode_t op, logic [31:0] serial, logic [31:0] mid,
                            logic [31:0] tmo, logic no_reply, logic is_call);
        table_op_t t;
        t.op                = op;
        t.serial            = serial;
        t.message_id        = mid;
        t.timeout_ticks     = tmo;
        t.no_reply_expected = no_reply;
        t.is_method_call    = is_call;
        send_word(t);
    endtask

    task automatic write_default_timeout(logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        shadow.set_default_timeout(value);
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (shadow.owed_count() != 0);
        repeat (4) @(posedge clk);
    endtask

    // mostly calls on a small serial pool so allocations, matches and expiry meet
    task automatic run_traffic(int count);
        table_op_t t;
        int        pick;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 30)
                t.op = OP_ALLOC;
            else if (pick < 42)
                t.op = OP_RELEASE;
            else if (pick < 60)
                t.op = OP_MATCH;
            else if (pick < 80)
                t.op = OP_TICK;
            else if (pick < 94)
                t.op = OP_POLL;
            else if (pick < 97)
                t.op = OP_CLEAR;
            else if (pick < 99)
                t.op = OP_UNUSED_6;
            else
                t.op = OP_UNUSED_7;
            pick = $urandom_range(99);
            if (pick < 70)
                t.serial = $urandom_range(4, 1);
            else if (pick < 80)
                t.serial = '0;
            else
                t.serial = $urandom;
            t.message_id = $urandom;
            pick = $urandom_range(99);
            if (pick < 40)
                t.timeout_ticks = '0;
            else if (pick < 80)
                t.timeout_ticks = $urandom_range(6, 1);
            else
                t.timeout_ticks = $urandom;
            t.no_reply_expected = ($urandom_range(7) == 0);
            t.is_method_call    = ($urandom_range(4) != 0);
            send_word(t);
        end
    endtask

    initial
    begin : stimulus
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_default_timeout(32'd0);
        drive_op(OP_TICK,     32'd0,          32'd0,          32'd0,          1'b0, 1'b0);
        drive_op(OP_POLL,     32'd0,          32'd0,          32'd0,          1'b0, 1'b0);
        drive_op(OP_MATCH,    32'd0,          32'hFFFF_FFFF,  32'd0,          1'b0, 1'b1);
        drive_op(OP_RELEASE,  32'd0,          32'd0,          32'd0,          1'b0, 1'b1);
        drive_op(OP_ALLOC,    32'd5,          32'h1111_2222,  32'd3,          1'b1, 1'b0);
        drive_op(OP_ALLOC,    32'd0,          32'hDEAD_BEEF,  32'd5,          1'b0, 1'b0);
        drive_op(OP_ALLOC,    32'hFFFF_FFFF,  32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b0, 1'b1);
        drive_op(OP_ALLOC,    32'd1,          32'h5A5A_5A5A,  32'd0,          1'b0, 1'b0);
        // table full
        drive_op(OP_ALLOC,    32'd2,          32'h0000_0001,  32'd1,          1'b0, 1'b0);
        drive_op(OP_RELEASE,  32'd1,          32'd0,          32'd0,          1'b0, 1'b0);
        drive_op(OP_POLL,     32'd0,          32'd0,          32'd0,          1'b0, 1'b0);
        drive_op(OP_TICK,     32'd0,          32'd0,          32'd0,          1'b0, 1'b0);
        drive_op(OP_POLL,     32'd0,          32'd0,          32'd0,          1'b0, 1'b0);
        drive_op(OP_POLL,     32'd0,          32'd0,          32'd0,          1'b0, 1'b0);
        drive_op(OP_RELEASE,  32'hFFFF_FFFF,  32'd0,          32'd0,          1'b0, 1'b1);
        drive_op(OP_ALLOC,    32'd7,          32'h1234_5678,  32'd2,          1'b0, 1'b0);
        repeat (3) drive_op(OP_TICK, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0);
        drive_op(OP_MATCH,    32'd7,          32'd0,          32'd0,          1'b0, 1'b0);
        drive_op(OP_MATCH,    32'd7,          32'd0,          32'd0,          1'b0, 1'b0);
        drive_op(OP_UNUSED_6, 32'hFFFF_FFFF,  32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b1, 1'b1);
        drive_op(OP_UNUSED_7, 32'd3,          32'd4,          32'd5,          1'b0, 1'b0);
        drive_op(OP_ALLOC,    32'd9,          32'h0BAD_F00D,  32'd4,          1'b0, 1'b0);
        drive_op(OP_CLEAR,    32'd0,          32'd0,          32'd0,          1'b0, 1'b0);
        drive_op(OP_MATCH,    32'd9,          32'd0,          32'd0,          1'b0, 1'b0);

        settle();
        write_default_timeout(32'd3);
        run_traffic(130);

        settle();
        write_default_timeout(32'hFFFF_FFFF);
        send_idle_pct = 67;
        run_traffic(130);

        settle();
        write_default_timeout(32'd1);
        send_idle_pct  = 0;
        recv_stall_pct = 67;
        run_traffic(130);

        settle();
        write_default_timeout(32'd20000);
        send_idle_pct  = 28;
        recv_stall_pct = 28;
        run_traffic(130);

        // long receiver hold-off while words keep coming
        settle();
        write_default_timeout(32'd2);
        send_idle_pct    = 0;
        recv_stall_pct   = 0;
        hold_off_request = 150;
        run_traffic(110);

        settle();
        repeat (10) @(posedge clk);
        if (shadow.err_count == 0 && shadow.owed_count() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ files.f @@
design/prt_pkg.sv
design/prt_ctrl.sv
design/prt_datapath.sv
design/pending_reply_table.sv
tb/tb_pending_reply_table.sv
